// File: rtl/core/wpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed posting accumulator package
// Opcodes, register indexes, transaction types and the saturating increment
// shared by the window cells and the top level.
// ----------------------------------------------------------------------------
package wpa_pkg;

  localparam int BOUND_REGS = 5;

  localparam logic [1:0] OP_ADD       = 2'd0;
  localparam logic [1:0] OP_FLUSH     = 2'd1;
  localparam logic [1:0] OP_QUERY_WIN = 2'd2;
  localparam logic [1:0] OP_QUERY_ALL = 2'd3;

  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_ANSWER = 1'b1;

  localparam logic [2:0] REG_WIN_COUNT   = 3'd0;
  localparam logic [2:0] REG_BOUND_FIRST = 3'd1;
  localparam logic [2:0] REG_BOUND_LAST  = 3'd5;

  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] doc_id;
    logic [15:0] distance;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] value;
    logic [2:0]  word_index;
    logic        found;
    logic [31:0] doc_count;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic update;
    logic clear;
    logic load;
    logic shift;
  } cell_ctrl_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == COUNT_MAX) ? v : v + 32'd1;
  endfunction

endpackage

// File: rtl/core/windowed_posting_accumulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed posting accumulator
// Builds link posting records from occurrence transactions and answers
// window and overall total queries.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry an opcode, a document id and a distance; out_valid/
//   out_ready carry record words and query answers, last set on the final
//   word caused by a transaction. cfg_wr_en/cfg_index/cfg_data write the
//   window count and the five window bounds while the block is idle.
//   Adds to the open record are accepted back to back, even while a record
//   is still being sent. A transaction that yields output shows its first
//   word in the cycle after acceptance. A record goes out one word a cycle
//   while the receiver is ready, through the snapshot chain in the window
//   cells, so a record-emitting transaction sends W + 2 words, W being
//   win_count held to 1..min(MAX_WINDOWS, 5); queries send one.
//   A transaction that yields output waits while a record is still being sent
//   or the output register is full and stalled; other adds keep flowing.
//   When the receiver holds out_ready low the current word holds.
//   Reset clears all counters, closes the record and restores the register
//   defaults (five windows, bounds 1, 2, 4, 8, 16).
// ----------------------------------------------------------------------------
module windowed_posting_accumulator #(
  parameter int MAX_WINDOWS = 5
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  wpa_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output wpa_pkg::out_item_t out_data,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import wpa_pkg::*;

  localparam int NCELL = (MAX_WINDOWS < BOUND_REGS) ? MAX_WINDOWS : BOUND_REGS;
  localparam logic [2:0] NCELL_W = 3'(NCELL);

  logic [2:0]  win_count;
  logic [15:0] bound [BOUND_REGS];
  logic [2:0]  bound_sel;
  logic [2:0]  w_eff;

  logic        record_open;
  logic [31:0] open_id;
  logic [31:0] open_total;
  logic [31:0] overall_total;
  logic [31:0] docs;
  logic [31:0] docs_next;

  logic        busy;
  logic [2:0]  word_k;
  logic [31:0] total_s;
  logic [31:0] docs_s;

  logic        is_add;
  logic        is_query;
  logic        new_doc;
  logic        emits_rec;
  logic        has_result;
  logic        can_load;
  logic        in_fire;
  logic        advance;
  cell_ctrl_t  ctrl;

  logic        hit_c    [NCELL+1];
  logic        found_c  [NCELL+1];
  logic [31:0] answer_c [NCELL+1];
  logic [31:0] shadow_c [NCELL+1];

  // configuration
  assign bound_sel = cfg_index - REG_BOUND_FIRST;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_count <= 3'd5;
      for (int i = 0; i < BOUND_REGS; i++) begin
        bound[i] <= 16'(1 << i);
      end
    end else if (cfg_wr_en) begin
      if (cfg_index == REG_WIN_COUNT) begin
        win_count <= cfg_data[2:0];
      end else if (cfg_index >= REG_BOUND_FIRST && cfg_index <= REG_BOUND_LAST) begin
        bound[bound_sel] <= cfg_data;
      end
    end
  end

  always_comb begin
    w_eff = win_count;
    if (win_count == 3'd0) begin
      w_eff = 3'd1;
    end else if (win_count > NCELL_W) begin
      w_eff = NCELL_W;
    end
  end

  // input decode and flow control
  assign is_add     = (in_data.opcode == OP_ADD);
  assign is_query   = (in_data.opcode == OP_QUERY_WIN) || (in_data.opcode == OP_QUERY_ALL);
  assign new_doc    = !record_open || (in_data.doc_id != open_id);
  assign emits_rec  = record_open && ((is_add && (in_data.doc_id != open_id)) ||
                                      (in_data.opcode == OP_FLUSH));
  assign has_result = emits_rec || is_query;
  assign can_load   = !busy && (!out_valid || out_ready);
  assign in_ready   = !has_result || can_load;
  assign in_fire    = in_valid && in_ready;
  assign advance    = busy && out_ready;

  assign docs_next  = (in_fire && is_add && new_doc) ? sat_inc(docs) : docs;

  assign ctrl.update = in_fire && is_add;
  assign ctrl.clear  = is_add && new_doc;
  assign ctrl.load   = in_fire && emits_rec;
  assign ctrl.shift  = advance && (word_k <= w_eff);

  // window cell row
  assign hit_c[0]        = 1'b0;
  assign found_c[0]      = 1'b0;
  assign answer_c[0]     = 32'd0;
  assign shadow_c[NCELL] = 32'd0;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    wpa_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .enabled    (3'(i) < w_eff),
      .distance   (in_data.distance),
      .bound_lo   ((i == 0) ? 16'd0 : bound[(i == 0) ? 0 : i - 1]),
      .bound_hi   (bound[i]),
      .hit_in     (hit_c[i]),
      .hit_out    (hit_c[i+1]),
      .found_in   (found_c[i]),
      .answer_in  (answer_c[i]),
      .found_out  (found_c[i+1]),
      .answer_out (answer_c[i+1]),
      .shadow_in  (shadow_c[i+1]),
      .shadow     (shadow_c[i])
    );
  end

  // open record and running totals
  always_ff @(posedge clk) begin
    if (rst) begin
      record_open   <= 1'b0;
      open_id       <= 32'd0;
      open_total    <= 32'd0;
      overall_total <= 32'd0;
      docs          <= 32'd0;
    end else if (in_fire) begin
      case (in_data.opcode)
        OP_ADD: begin
          record_open   <= 1'b1;
          open_id       <= in_data.doc_id;
          open_total    <= sat_inc(new_doc ? 32'd0 : open_total);
          overall_total <= sat_inc(overall_total);
          docs          <= docs_next;
        end
        OP_FLUSH: begin
          record_open <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // output register and record sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      busy      <= 1'b0;
      word_k    <= 3'd0;
    end else if (ctrl.load) begin
      out_valid <= 1'b1;
      busy      <= 1'b1;
      word_k    <= 3'd1;
    end else if (in_fire && is_query) begin
      out_valid <= 1'b1;
    end else if (advance) begin
      word_k <= word_k + 3'd1;
      if (word_k > w_eff) begin
        busy <= 1'b0;
      end
    end else if (out_valid && out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      out_data <= '{KIND_RECORD, open_id, 3'd0, 1'b0, docs_next, 1'b0};
      total_s  <= open_total;
      docs_s   <= docs_next;
    end else if (in_fire && is_query) begin
      if (in_data.opcode == OP_QUERY_WIN) begin
        out_data <= '{KIND_ANSWER, answer_c[NCELL], 3'd0, found_c[NCELL], docs, 1'b1};
      end else begin
        out_data <= '{KIND_ANSWER, overall_total, 3'd0, 1'b0, docs, 1'b1};
      end
    end else if (advance) begin
      if (word_k <= w_eff) begin
        out_data <= '{KIND_RECORD, shadow_c[0], word_k, 1'b0, docs_s, 1'b0};
      end else begin
        out_data <= '{KIND_RECORD, total_s, word_k, 1'b0, docs_s, 1'b1};
      end
    end
  end

  a_busy_has_word: assert property (@(posedge clk) disable iff (rst)
    busy |-> out_valid)
    else $error("record in progress without a word on the output");

  a_last_ends_record: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.last |-> !busy)
    else $error("final word shown while record words remain");

  a_word_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (word_k != 3'd0) && (word_k <= w_eff + 3'd1))
    else $error("record word index out of range");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_fire && has_result |=> out_valid)
    else $error("accepted transaction produced no output word");

  a_flush_closes: assert property (@(posedge clk) disable iff (rst)
    in_fire && (in_data.opcode == OP_FLUSH) |=> !record_open)
    else $error("record still open after flush");

endmodule

// File: rtl/core/wpa_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window cell
// Holds the open record count and running total of one distance window,
// passes the hit and query match down the row and shifts its record
// snapshot toward the output end.
// ----------------------------------------------------------------------------
module wpa_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  wpa_pkg::cell_ctrl_t  ctrl,
  input  logic                 enabled,
  input  logic [15:0]          distance,
  input  logic [15:0]          bound_lo,
  input  logic [15:0]          bound_hi,
  input  logic                 hit_in,
  output logic                 hit_out,
  input  logic                 found_in,
  input  logic [31:0]          answer_in,
  output logic                 found_out,
  output logic [31:0]          answer_out,
  input  logic [31:0]          shadow_in,
  output logic [31:0]          shadow
);
  import wpa_pkg::*;

  logic [31:0] count;
  logic [31:0] total;
  logic [31:0] count_base;
  logic        own_hit;
  logic        own_match;
  logic        bump;

  assign own_hit    = enabled && (distance > bound_lo) && (distance <= bound_hi);
  assign hit_out    = hit_in || own_hit;
  assign bump       = ctrl.update && enabled && hit_out;
  assign count_base = ctrl.clear ? 32'd0 : count;

  assign own_match  = enabled && (distance == bound_hi);
  assign found_out  = found_in || own_match;
  assign answer_out = found_in ? answer_in : (own_match ? total : 32'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 32'd0;
      total <= 32'd0;
    end else begin
      if (ctrl.update) begin
        count <= bump ? sat_inc(count_base) : count_base;
      end
      if (bump) begin
        total <= sat_inc(total);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      shadow <= count;
    end else if (ctrl.shift) begin
      shadow <= shadow_in;
    end
  end

endmodule
